@@ hdl/acrb_pkg.sv @@
`timescale 1ns / 1ps

package acrb_pkg;

    localparam int RING_FRAMES  = 4096;
    localparam int MAX_CHANNELS = 2;
    localparam int SAMPLE_BITS  = 24;

    localparam int RING_AW = $clog2(RING_FRAMES);
    localparam int FILL_W  = $clog2(RING_FRAMES + 1);
    localparam int FRAME_W = 2 * SAMPLE_BITS;

    // op codes
    localparam logic [2:0] OP_CAPTURE = 3'd0;
    localparam logic [2:0] OP_DRAIN   = 3'd1;
    localparam logic [2:0] OP_STATUS  = 3'd2;
    localparam logic [2:0] OP_START   = 3'd3;
    localparam logic [2:0] OP_STOP    = 3'd4;

    // status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOTHING = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;
    localparam logic [1:0] ST_DROPPED = 2'd3;

    typedef struct packed {
        logic [2:0]                    op;
        logic signed [SAMPLE_BITS-1:0] sample_first;
        logic signed [SAMPLE_BITS-1:0] sample_second;
        logic [3:0]                    in_channels;
        logic                          block_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                    status_code;
        logic                          out_valid;
        logic signed [SAMPLE_BITS-1:0] out_first;
        logic signed [SAMPLE_BITS-1:0] out_second;
        logic [1:0]                    take_channels;
        logic                          is_recording;
        logic [SAMPLE_BITS-1:0]        peak_level;
        logic [31:0]                   take_frame_count;
        logic [31:0]                   dropped_count;
        logic [FILL_W-1:0]             ring_fill;
        logic                          take_empty;
    } out_item_t;

    // Result of one item before the ring read data joins it
    typedef struct packed {
        logic [1:0]             status_code;
        logic                   out_valid;
        logic                   second_en;
        logic [1:0]             take_channels;
        logic                   is_recording;
        logic [SAMPLE_BITS-1:0] peak_level;
        logic [31:0]            take_frame_count;
        logic [31:0]            dropped_count;
        logic [FILL_W-1:0]      ring_fill;
        logic                   take_empty;
    } core_res_t;

    typedef struct packed {
        logic               we;
        logic [RING_AW-1:0] waddr;
        logic [FRAME_W-1:0] wdata;
        logic               re;
        logic [RING_AW-1:0] raddr;
    } ring_ctl_t;

endpackage

@@ hdl/audio_capture_ring_buffer.sv @@
`timescale 1ns / 1ps
// An accepted input item is held in the input register and moves on to the result register
//   once that register is free; the output transfer is taken from the result register.
// Throughput: one item per cycle while the output is not stalled; the ring RAM has one write
//   and one registered read port, and all pointer/counter updates are made as the item moves on.
// Reset (rst_n, async, active low) clears pointers, counters, flags, peak and the
//   skip count; ring contents stay undefined and need no clearing pass.
module audio_capture_ring_buffer
    import acrb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        res_valid,
    input  logic        res_ready,
    output out_item_t   res_data,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    // Stage 1: input register holds one accepted item
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    // Stage 2: result register; sample data comes from the RAM read register
    logic      res_valid_reg;
    core_res_t res_reg;

    logic               fire;
    core_res_t          core_res;
    ring_ctl_t          ring_ctl;
    logic [FRAME_W-1:0] ring_q;

    // item moves from input register to result register when the result slot frees
    assign fire     = s1_valid_reg && (!res_valid_reg || res_ready);
    assign in_ready = !s1_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_data;
        end
    end

    acrb_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .item     (s1_item_reg),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .res      (core_res),
        .ring_ctl (ring_ctl)
    );

    // RAM read is enabled on fire, so its data register stalls together with res_reg
    acrb_ring #(
        .WIDTH(FRAME_W),
        .DEPTH(RING_FRAMES)
    ) u_ring (
        .clk  (clk),
        .we   (ring_ctl.we),
        .waddr(ring_ctl.waddr),
        .wdata(ring_ctl.wdata),
        .re   (ring_ctl.re),
        .raddr(ring_ctl.raddr),
        .rdata(ring_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (!res_valid_reg || res_ready)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= core_res;
        end
    end

    // Output transfer assembly: samples are zero unless a frame was drained,
    // second sample zero for a mono take
    always_comb
    begin
        res_data.status_code      = res_reg.status_code;
        res_data.out_valid        = res_reg.out_valid;
        res_data.out_first        = res_reg.out_valid ? ring_q[FRAME_W-1:SAMPLE_BITS]
                                                      : SAMPLE_BITS'(0);
        res_data.out_second       = (res_reg.out_valid && res_reg.second_en)
                                    ? ring_q[SAMPLE_BITS-1:0] : SAMPLE_BITS'(0);
        res_data.take_channels    = res_reg.take_channels;
        res_data.is_recording     = res_reg.is_recording;
        res_data.peak_level       = res_reg.peak_level;
        res_data.take_frame_count = res_reg.take_frame_count;
        res_data.dropped_count    = res_reg.dropped_count;
        res_data.ring_fill        = res_reg.ring_fill;
        res_data.take_empty       = res_reg.take_empty;
    end

    assign res_valid = res_valid_reg;

    // ring never reports more frames than it holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.ring_fill <= FILL_W'(RING_FRAMES)))
        else $error("ring fill above capacity");

    // a drained frame always comes with a done status
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.out_valid) |-> (res_reg.status_code == ST_DONE))
        else $error("drained frame without done status");

    // take_empty only reported on a stop that ended recording
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.take_empty)
            |-> (!res_reg.is_recording && res_reg.status_code == ST_DONE))
        else $error("take_empty outside an accepted stop");

    // a stalled result keeps its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> $stable(res_reg))
        else $error("result register changed while stalled");

endmodule

@@ hdl/acrb_ring.sv @@
`timescale 1ns / 1ps

module acrb_ring #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/acrb_core.sv @@
`timescale 1ns / 1ps

module acrb_core
    import acrb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    input  logic      cfg_we,
    input  logic [31:0] cfg_wdata,
    output core_res_t res,
    output ring_ctl_t ring_ctl
);

    logic [RING_AW-1:0]     wr_idx_reg, wr_idx_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic                   rec_reg, rec_next;
    logic [1:0]             chan_reg, chan_next;
    logic [SAMPLE_BITS-1:0] peak_reg, peak_next;
    logic [31:0]            deliv_reg, deliv_next;
    logic [31:0]            lost_reg, lost_next;
    logic [31:0]            skip_left_reg, skip_left_next;
    logic [31:0]            skip_cfg_reg;

    logic [1:0]             ch;
    logic [SAMPLE_BITS-1:0] mag1, mag2, frame_peak;
    logic [FILL_W-1:0]      wr_ext;
    logic [FILL_W-1:0]      rd_ext;
    logic                   valid_o;
    logic                   tempty_o;
    logic [1:0]             status_o;

    // magnitude fits the unsigned sample width, the most negative value included
    assign mag1 = item.sample_first[SAMPLE_BITS-1]
                ? (~item.sample_first + 1'b1) : item.sample_first;
    assign mag2 = item.sample_second[SAMPLE_BITS-1]
                ? (~item.sample_second + 1'b1) : item.sample_second;
    assign ch   = (item.in_channels > 4'(MAX_CHANNELS)) ? 2'(MAX_CHANNELS)
                                                        : item.in_channels[1:0];
    assign frame_peak = (ch >= 2'd2 && mag2 > mag1) ? mag2 : mag1;

    // oldest frame sits fill entries behind the write pointer
    assign wr_ext = FILL_W'(wr_idx_reg);
    assign rd_ext = (wr_ext >= fill_reg) ? (wr_ext - fill_reg)
                                         : (wr_ext + FILL_W'(RING_FRAMES) - fill_reg);

    always_comb
    begin
        wr_idx_next    = wr_idx_reg;
        fill_next      = fill_reg;
        rec_next       = rec_reg;
        chan_next      = chan_reg;
        peak_next      = peak_reg;
        deliv_next     = deliv_reg;
        lost_next      = lost_reg;
        skip_left_next = skip_left_reg;
        status_o       = ST_NOTHING;
        valid_o        = 1'b0;
        tempty_o       = 1'b0;
        ring_ctl.we    = 1'b0;
        ring_ctl.waddr = wr_idx_reg;
        ring_ctl.wdata = {item.sample_first,
                          (ch >= 2'd2) ? item.sample_second : SAMPLE_BITS'(0)};
        ring_ctl.re    = fire;
        ring_ctl.raddr = rd_ext[RING_AW-1:0];

        case (item.op)
            OP_CAPTURE:
            begin
                if (item.in_channels != 4'd0)
                begin
                    if (frame_peak > peak_reg)
                    begin
                        peak_next = frame_peak;
                    end
                    if (rec_reg)
                    begin
                        if (chan_reg == 2'd0)
                        begin
                            chan_next = ch;
                        end
                        if (fill_reg >= FILL_W'(RING_FRAMES))
                        begin
                            if (lost_reg != 32'hFFFF_FFFF)
                            begin
                                lost_next = lost_reg + 32'd1;
                            end
                            status_o = ST_DROPPED;
                        end
                        else
                        begin
                            ring_ctl.we = fire;
                            wr_idx_next = (wr_idx_reg == RING_AW'(RING_FRAMES - 1))
                                        ? '0 : wr_idx_reg + 1'b1;
                            fill_next   = fill_reg + 1'b1;
                            status_o    = ST_DONE;
                        end
                    end
                end
            end
            OP_DRAIN:
            begin
                if (fill_reg != '0 && chan_reg != 2'd0)
                begin
                    fill_next = fill_reg - 1'b1;
                    status_o  = ST_DONE;
                    if (skip_left_reg != 32'd0)
                    begin
                        skip_left_next = skip_left_reg - 32'd1;
                    end
                    else
                    begin
                        valid_o = 1'b1;
                        if (deliv_reg != 32'hFFFF_FFFF)
                        begin
                            deliv_next = deliv_reg + 32'd1;
                        end
                    end
                end
            end
            OP_STATUS:
            begin
                status_o  = ST_DONE;
                peak_next = '0;
            end
            OP_START:
            begin
                if (rec_reg)
                begin
                    status_o = ST_REFUSED;
                end
                else
                begin
                    deliv_next     = '0;
                    lost_next      = '0;
                    skip_left_next = skip_cfg_reg;
                    chan_next      = 2'd0;
                    fill_next      = '0;
                    rec_next       = 1'b1;
                    status_o       = ST_DONE;
                end
            end
            OP_STOP:
            begin
                if (!rec_reg)
                begin
                    status_o = ST_REFUSED;
                end
                else
                begin
                    rec_next = 1'b0;
                    tempty_o = (chan_reg == 2'd0) || (deliv_reg == 32'd0);
                    status_o = ST_DONE;
                end
            end
            default:
            begin
                status_o = ST_NOTHING;
            end
        endcase
    end

    always_comb
    begin
        res.status_code      = status_o;
        res.out_valid        = valid_o;
        res.second_en        = (chan_reg >= 2'd2);
        res.take_channels    = chan_next;
        res.is_recording     = rec_next;
        res.peak_level       = (item.op == OP_STATUS) ? peak_reg : peak_next;
        res.take_frame_count = deliv_next;
        res.dropped_count    = lost_next;
        res.ring_fill        = fill_next;
        res.take_empty       = tempty_o;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg    <= '0;
            fill_reg      <= '0;
            rec_reg       <= 1'b0;
            chan_reg      <= 2'd0;
            peak_reg      <= '0;
            deliv_reg     <= '0;
            lost_reg      <= '0;
            skip_left_reg <= '0;
        end
        else if (fire)
        begin
            wr_idx_reg    <= wr_idx_next;
            fill_reg      <= fill_next;
            rec_reg       <= rec_next;
            chan_reg      <= chan_next;
            peak_reg      <= peak_next;
            deliv_reg     <= deliv_next;
            lost_reg      <= lost_next;
            skip_left_reg <= skip_left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            skip_cfg_reg <= cfg_wdata;
        end
    end

endmodule
